@@ rtl/core/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// shared constants for the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ENTRY_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ENTRIES    = 9;

  // result tuser bit positions
  localparam int USER_SINGULAR  = 0;
  localparam int USER_SATURATED = 1;
  localparam int USER_BITS      = 2;

endpackage

@@ rtl/core/matrix3x3_inverse_core.sv @@
// an input transfer passes stages 1 to 6, the division array and the output register
// throughput: one matrix per cycle when not stalled; the divider is a restoring
//   array with one quotient bit per pipeline stage, one array per matrix entry
// a stall on the result side freezes the whole pipeline
// reset clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// inverse of a signed fixed-point 3x3 matrix by adjugate over determinant,
// truncated toward zero and saturated, with singular and saturated flags
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
  parameter int ENTRY_BITS = mi3_pkg::ENTRY_BITS_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33
  input  logic [((9*ENTRY_BITS+7)/8)*8-1:0]          s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33
  output logic [((9*ENTRY_BITS+7)/8)*8-1:0]          m_tdata,
  // singular, saturated
  output logic [mi3_pkg::USER_BITS-1:0]              m_tuser
);
  import mi3_pkg::*;

  localparam int E   = ENTRY_BITS;
  localparam int N   = NUM_ENTRIES;
  localparam int TW  = ((9*ENTRY_BITS+7)/8)*8;
  localparam int PW  = 2*E;
  localparam int CW  = 2*E+1;
  localparam int LPW = 2*E+1;
  localparam int DW  = 3*E+1;
  localparam int MW  = 3*E;
  localparam int NW  = 2*E+2*FRAC_BITS;
  localparam int RW  = (NW > MW+E) ? NW : MW+E;

  logic en;
  logic signed [E-1:0] a [N];

  // stage 1: products
  logic              v1;
  logic signed [PW-1:0] pa [N];
  logic signed [PW-1:0] pb [N];
  logic signed [E-1:0]  a1 [3];
  // stage 2: cofactors
  logic              v2;
  logic signed [CW-1:0] cof2 [N];
  logic signed [E-1:0]  a2 [3];
  // stage 3: split determinant products
  logic              v3;
  logic signed [CW-1:0]  cof3 [N];
  logic signed [LPW-1:0] plo [3];
  logic signed [LPW-1:0] phi [3];
  // stage 4: terms
  logic              v4;
  logic signed [CW-1:0] cof4 [N];
  logic signed [DW-1:0] term [3];
  // stage 5: determinant
  logic              v5;
  logic signed [CW-1:0] cof5 [N];
  logic signed [DW-1:0] det;
  // stage 6: magnitudes
  logic              v6;
  logic [NW-1:0]     nmag [N];
  logic [MW-1:0]     dmag6;
  logic [N-1:0]      neg6;
  logic              sing6;
  // division array, index k is the input of quotient step k
  logic              dv   [E+1];
  logic [RW-1:0]     dr   [E+1][N];
  logic [E-1:0]      dq   [E+1][N];
  logic [MW-1:0]     dd   [E+1];
  logic [N-1:0]      dneg [E+1];
  logic [N-1:0]      dovf [E+1];
  logic              dsing[E+1];

  logic [TW-1:0]     res_data;
  logic              res_sat;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      a[j] = s_tdata[j*E +: E];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      for (int k = 0; k <= E; k++) begin
        dv[k] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      dv[0] <= v6;
      for (int k = 0; k < E; k++) begin
        dv[k+1] <= dv[k];
      end
      m_tvalid <= dv[E];
    end
  end

  // cofactor operands follow the adjugate of the transposed layout
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= PW'(a[4]) * PW'(a[8]);  pb[0] <= PW'(a[5]) * PW'(a[7]);
      pa[1] <= PW'(a[2]) * PW'(a[7]);  pb[1] <= PW'(a[1]) * PW'(a[8]);
      pa[2] <= PW'(a[1]) * PW'(a[5]);  pb[2] <= PW'(a[2]) * PW'(a[4]);
      pa[3] <= PW'(a[5]) * PW'(a[6]);  pb[3] <= PW'(a[3]) * PW'(a[8]);
      pa[4] <= PW'(a[0]) * PW'(a[8]);  pb[4] <= PW'(a[2]) * PW'(a[6]);
      pa[5] <= PW'(a[2]) * PW'(a[3]);  pb[5] <= PW'(a[0]) * PW'(a[5]);
      pa[6] <= PW'(a[3]) * PW'(a[7]);  pb[6] <= PW'(a[4]) * PW'(a[6]);
      pa[7] <= PW'(a[1]) * PW'(a[6]);  pb[7] <= PW'(a[0]) * PW'(a[7]);
      pa[8] <= PW'(a[0]) * PW'(a[4]);  pb[8] <= PW'(a[1]) * PW'(a[3]);
      for (int i = 0; i < 3; i++) begin
        a1[i] <= a[i];
      end

      for (int j = 0; j < N; j++) begin
        cof2[j] <= CW'(pa[j]) - CW'(pb[j]);
      end
      a2 <= a1;

      cof3 <= cof2;
      for (int i = 0; i < 3; i++) begin
        plo[i] <= LPW'(a2[i]) * LPW'($signed({1'b0, cof2[3*i][E-1:0]}));
        phi[i] <= LPW'(a2[i]) * LPW'($signed(cof2[3*i][CW-1:E]));
      end

      cof4 <= cof3;
      for (int i = 0; i < 3; i++) begin
        term[i] <= (DW'(phi[i]) <<< E) + DW'(plo[i]);
      end

      cof5 <= cof4;
      det  <= term[0] + term[1] + term[2];

      for (int j = 0; j < N; j++) begin
        neg6[j] <= cof5[j][CW-1] ^ det[DW-1];
        nmag[j] <= {(cof5[j][CW-1] ? PW'(-cof5[j]) : PW'(cof5[j])), {(2*FRAC_BITS){1'b0}}};
      end
      dmag6 <= det[DW-1] ? MW'(-det) : MW'(det);
      sing6 <= (det == '0);

      dd[0]    <= dmag6;
      dneg[0]  <= neg6;
      dsing[0] <= sing6;
      for (int j = 0; j < N; j++) begin
        dr[0][j]   <= RW'(nmag[j]);
        dq[0][j]   <= '0;
        dovf[0][j] <= RW'(nmag[j]) >= (RW'(dmag6) << E);
      end

      for (int k = 0; k < E; k++) begin
        dd[k+1]    <= dd[k];
        dneg[k+1]  <= dneg[k];
        dovf[k+1]  <= dovf[k];
        dsing[k+1] <= dsing[k];
        for (int j = 0; j < N; j++) begin
          if (dr[k][j] >= (RW'(dd[k]) << (E-1-k))) begin
            dr[k+1][j] <= dr[k][j] - (RW'(dd[k]) << (E-1-k));
            dq[k+1][j] <= dq[k][j] | (E'(1) << (E-1-k));
          end else begin
            dr[k+1][j] <= dr[k][j];
            dq[k+1][j] <= dq[k][j];
          end
        end
      end

      m_tdata                 <= res_data;
      m_tuser[USER_SINGULAR]  <= dsing[E];
      m_tuser[USER_SATURATED] <= res_sat;
    end
  end

  // saturate, apply sign and pack; a singular result is all zeros
  always_comb begin
    logic [E-1:0] limit;
    logic [E-1:0] mag;
    logic         sat;
    res_data = '0;
    res_sat  = 1'b0;
    for (int j = 0; j < N; j++) begin
      limit = dneg[E][j] ? (E'(1) << (E-1)) : ((E'(1) << (E-1)) - E'(1));
      sat   = dovf[E][j] || (dq[E][j] > limit);
      mag   = sat ? limit : dq[E][j];
      if (!dsing[E]) begin
        res_data[j*E +: E] = dneg[E][j] ? E'(-mag) : mag;
        res_sat = res_sat | sat;
      end
    end
  end

`ifndef SYNTHESIS
  a_sing_not_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_SINGULAR] |-> !m_tuser[USER_SATURATED])
    else $error("singular result flagged saturated");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_SINGULAR] |-> (m_tdata == '0))
    else $error("singular result not zero");
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow pipeline advance");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed 3x3 matrices streamed into the inverse core; each result
// transfer is checked against an exact adjugate-over-determinant prediction
// ----------------------------------------------------------------------------
module tb_top;
  import mi3_pkg::*;

  localparam int EB = ENTRY_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = ((9*EB+7)/8)*8;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [DW-1:0] data;
    logic          sing;
    logic          sat;
  } inv_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [DW-1:0] m_tdata;
  logic [USER_BITS-1:0] m_tuser;

  logic [DW-1:0] pending_mats[$];
  inv_t expected_inv[$];
  int errors = 0;
  int checked = 0;
  int singular_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit feeding = 1;
  bit in_taken = 0;

  always #1 clk = ~clk;

  matrix3x3_inverse_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic logic signed [255:0] ent(logic [DW-1:0] d, int k);
    logic signed [EB-1:0] v;
    v = d[k*EB +: EB];
    return 256'(v);
  endfunction

  function automatic inv_t invert3(logic [DW-1:0] d);
    inv_t r;
    logic signed [255:0] a[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det, q, nmag, dmag;
    logic signed [255:0] maxp, minn;
    logic signed [EB-1:0] e;
    r.data = '0; r.sing = 0; r.sat = 0;
    for (int k = 0; k < 9; k++) a[k] = ent(d, k);
    adj[0] = a[4]*a[8] - a[5]*a[7];
    adj[1] = a[2]*a[7] - a[1]*a[8];
    adj[2] = a[1]*a[5] - a[2]*a[4];
    adj[3] = a[5]*a[6] - a[3]*a[8];
    adj[4] = a[0]*a[8] - a[2]*a[6];
    adj[5] = a[2]*a[3] - a[0]*a[5];
    adj[6] = a[3]*a[7] - a[4]*a[6];
    adj[7] = a[1]*a[6] - a[0]*a[7];
    adj[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
    if (det == 0) begin
      r.sing = 1;
      return r;
    end
    maxp = (256'sd1 <<< (EB-1)) - 1;
    minn = -(256'sd1 <<< (EB-1));
    for (int k = 0; k < 9; k++) begin
      nmag = (adj[k] < 0) ? -adj[k] : adj[k];
      dmag = (det < 0) ? -det : det;
      q = (nmag <<< (2*FB)) / dmag;
      if ((adj[k] < 0) != (det < 0)) q = -q;
      if (q > maxp) begin
        q = maxp; r.sat = 1;
      end else if (q < minn) begin
        q = minn; r.sat = 1;
      end
      e = q[EB-1:0];
      r.data[k*EB +: EB] = e;
    end
    return r;
  endfunction

  function automatic logic [EB-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return EB'(1 << FB) * EB'($urandom_range(0, 3)) - EB'($urandom_range(0, 1) << FB);
      1: return EB'($urandom_range(0, 15)) - EB'(8);
      2: return {1'b1, {(EB-1){1'b0}}} | EB'($urandom_range(0, 3));
      3: return {1'b0, {(EB-1){1'b1}}} - EB'($urandom_range(0, 3));
      default: return EB'($urandom);
    endcase
  endfunction

  function automatic logic [DW-1:0] pack9(logic [EB-1:0] e[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*EB +: EB] = e[k];
    return d;
  endfunction

  initial begin
    logic [EB-1:0] e[9];
    logic [EB-1:0] one, mx, mn;
    one = EB'(1 << FB);
    mx = {1'b0, {(EB-1){1'b1}}};
    mn = {1'b1, {(EB-1){1'b0}}};
    // identity, scaled identity, zero, singular rows, extremes
    e = '{one, 0, 0, 0, one, 0, 0, 0, one}; pending_mats.push_back(pack9(e));
    e = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; pending_mats.push_back(pack9(e));
    e = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; pending_mats.push_back(pack9(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; pending_mats.push_back(pack9(e));
    e = '{one, one, one, one, one, one, one, one, one}; pending_mats.push_back(pack9(e));
    e = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; pending_mats.push_back(pack9(e));
    e = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; pending_mats.push_back(pack9(e));
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; pending_mats.push_back(pack9(e));
    e = '{-EB'(1), 0, 0, 0, 1, 0, 0, 0, 1}; pending_mats.push_back(pack9(e));
    e = '{mx, mn, mx, mn, mx, mn, mx, mn, mn}; pending_mats.push_back(pack9(e));
    e = '{mn, mx, 0, mx, mn, 0, 0, 0, one}; pending_mats.push_back(pack9(e));
    e = '{0, one, 0, one, 0, 0, 0, 0, one}; pending_mats.push_back(pack9(e));
    e = '{one, EB'(2)*one, EB'(3)*one, EB'(4)*one, EB'(5)*one, EB'(6)*one,
          EB'(7)*one, EB'(8)*one, EB'(10)*one};
    pending_mats.push_back(pack9(e));
    pending_mats.push_back({DW{1'b1}});
    pending_mats.push_back({(DW/2){2'b01}});
    pending_mats.push_back({(DW/2){2'b10}});
    for (int n = 0; n < 2000; n++) begin
      for (int k = 0; k < 9; k++) e[k] = rand_entry();
      if ($urandom_range(0, 9) == 0) begin
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end
      pending_mats.push_back(pack9(e));
    end
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;
  end

  // driver: bursts with gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (burst_left > 0 && pending_mats.size() > 0) begin
          s_tdata <= pending_mats.pop_front();
          s_tvalid <= 1;
          burst_left--;
        end else begin
          s_tvalid <= 0;
          if (gap_left > 0) gap_left--;
          else burst_left = 0;
        end
      end
      case (($time / 200) % 4)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    inv_t x;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_inv.push_back(invert3(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_inv.size() == 0) begin
          $display("%0t: unexpected result data=%h user=%b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          x = expected_inv.pop_front();
          checked++;
          if (x.sing) singular_seen++;
          if (x.sat) saturated_seen++;
          for (int k = 0; k < 9; k++)
            if (m_tdata[k*EB +: EB] !== x.data[k*EB +: EB]) begin
              $display("%0t: entry %0d expected %h actual %h", $time, k,
                       x.data[k*EB +: EB], m_tdata[k*EB +: EB]);
              errors++;
            end
          if (m_tuser[USER_SINGULAR] !== x.sing || m_tuser[USER_SATURATED] !== x.sat) begin
            $display("%0t: flags expected sing=%b sat=%b actual %b", $time,
                     x.sing, x.sat, m_tuser);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(negedge rst);
    fork
      begin
        wait (pending_mats.size() == 0 && !s_tvalid && expected_inv.size() == 0);
        repeat (2*EB + 20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
      end
    join_any
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      $display("checked %0d inverses, %0d singular, %0d saturated",
               checked, singular_seen, saturated_seen);
      if (errors == 0) begin
        $display("tb_top: clean");
      end else begin
        $display("tb_top: errors");
      end
      $finish;
    end
  end
endmodule

@@ matrix3x3_inverse_core.f @@
rtl/core/mi3_pkg.sv
rtl/core/matrix3x3_inverse_core.sv
test/tb_top.sv
